/* rtl/core/frnq_pkg.sv */
package frnq_pkg;

	// table geometry
	localparam int MAX_ITEMS = 64;
	localparam int IDX_W     = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

	// field widths
	localparam int COORD_W = 24;
	localparam int RAD_W   = 23;
	localparam int OUT_IDX_W = 6;
	localparam int SQ_W    = 2 * COORD_W;
	localparam int SUM_W   = SQ_W + 1;
	localparam int R2_W    = 2 * RAD_W;

	// request opcodes
	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_ADD   = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;

	// result status codes
	localparam logic [2:0] ST_ADDED   = 3'd0;
	localparam logic [2:0] ST_FULL    = 3'd1;
	localparam logic [2:0] ST_CLEARED = 3'd2;
	localparam logic [2:0] ST_MATCH   = 3'd3;
	localparam logic [2:0] ST_NOMATCH = 3'd4;

	// scan token moving down the distance pipeline
	typedef struct packed {
		logic               vld;
		logic               fin;  // end-of-scan marker, carries no entry
		logic [CNT_W-1:0]   idx;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] z;
	} tag_t;

	// low bits of an entry index as shown on the index port
	function automatic logic [OUT_IDX_W-1:0] out_index(input logic [CNT_W-1:0] i);
		logic [CNT_W+OUT_IDX_W-1:0] t;
		t = {{OUT_IDX_W{1'b0}}, i};
		return t[OUT_IDX_W-1:0];
	endfunction

endpackage

/* rtl/core/frnq_dist.sv */
module frnq_dist (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       adv,
	input  frnq_pkg::tag_t             tag_in,
	input  logic [frnq_pkg::COORD_W-1:0] ctr_x,
	input  logic [frnq_pkg::COORD_W-1:0] ctr_z,
	output frnq_pkg::tag_t             tag_out,
	output logic [frnq_pkg::SQ_W-1:0]  sqx,
	output logic [frnq_pkg::SQ_W-1:0]  sqz
);
	import frnq_pkg::*;

	logic [COORD_W:0]   dx, dz;
	logic [COORD_W:0]   ax, az;
	logic [COORD_W-1:0] ax_s2, az_s2;
	logic [SQ_W-1:0]    sqx_s3, sqz_s3;
	tag_t               tag_s2, tag_s3;

	// sign-extended differences and magnitudes; |d| always fits COORD_W bits
	always_comb begin
		dx = {tag_in.x[COORD_W-1], tag_in.x} - {ctr_x[COORD_W-1], ctr_x};
		dz = {tag_in.z[COORD_W-1], tag_in.z} - {ctr_z[COORD_W-1], ctr_z};
		ax = dx[COORD_W] ? (~dx + 1'b1) : dx;
		az = dz[COORD_W] ? (~dz + 1'b1) : dz;
	end

	// token control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else if (adv) begin
			tag_s2 <= tag_in;
			tag_s3 <= tag_s2;
		end
	end

	// magnitude then square stages
	always_ff @(posedge clk) begin
		if (adv) begin
			ax_s2  <= ax[COORD_W-1:0];
			az_s2  <= az[COORD_W-1:0];
			sqx_s3 <= SQ_W'(ax_s2) * SQ_W'(ax_s2);
			sqz_s3 <= SQ_W'(az_s2) * SQ_W'(az_s2);
		end
	end

	assign tag_out = tag_s3;
	assign sqx     = sqx_s3;
	assign sqz     = sqz_s3;

endmodule

/* rtl/core/fixed_radius_neighbor_query.sv */
// Fixed-radius neighbor table with a single request channel and a single
// result channel, both valid/stall.
// Requests: clear (opcode 0), add point (1), radius query (2); opcode 3 is
// taken and dropped with no result.
// Clear and add each give a single result, which shows on the result port
// the next cycle.
// A query reads the point memory one entry per cycle while the result side
// is not stalled: with N stored points it issues N reads plus one end token,
// and the tokens run through a four-stage read/difference/square/compare
// pipeline. No new request is taken until the end token has left it.
// Matches come out in ascending index order; the last result of every
// request has last set. A no-match query gives one result with status 4.
// Reset empties the table (count to zero) and drops any result in flight;
// the point memory itself is not cleared and needs no sweep.
// While the receiver stalls a waiting result, the whole scan pipeline
// freezes and no new request is taken.
module fixed_radius_neighbor_query (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic signed [23:0] pos_x,
	input  logic signed [23:0] pos_z,
	input  logic [22:0] radius,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [5:0]  index,
	output logic signed [23:0] match_x,
	output logic signed [23:0] match_z,
	output logic        last
);
	import frnq_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_WAIT = 2'd2;

	logic [1:0]           state_q;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     scan_q;
	logic [COORD_W-1:0]   cx_q, cz_q;
	logic [R2_W-1:0]      r2_q;

	logic [2*COORD_W-1:0] mem [MAX_ITEMS];
	logic [2*COORD_W-1:0] rd_s1;
	logic                 vld_s1, fin_s1;
	logic [CNT_W-1:0]     idx_s1;

	tag_t                 tag_rd, tag_s3;
	logic [SQ_W-1:0]      sqx, sqz;
	logic [SUM_W-1:0]     d2;
	logic                 hit;

	logic                 pend_v_q;
	logic [CNT_W-1:0]     pend_idx_q;
	logic [COORD_W-1:0]   pend_x_q, pend_z_q;

	logic                 out_free, adv, in_acc, issue, rd_en, wr_en, full;
	logic                 emit;
	logic [2:0]           e_st;
	logic [OUT_IDX_W-1:0] e_idx;
	logic [COORD_W-1:0]   e_x, e_z;
	logic                 e_last;

	// handshake
	assign out_free = !out_valid || !out_stall;
	assign adv      = out_free;
	assign in_stall = !((state_q == S_IDLE) && out_free);
	assign in_acc   = in_valid && !in_stall;
	assign full     = (count_q == CNT_W'(MAX_ITEMS));
	assign wr_en    = in_acc && (opcode == OP_ADD) && !full;
	assign issue    = adv && (state_q == S_SCAN);
	assign rd_en    = issue && (scan_q < count_q);

	// point memory; writes happen only when idle, reads only during a scan,
	// so the two never touch the same entry at once
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[count_q[IDX_W-1:0]] <= {pos_x, pos_z};
		if (rd_en)
			rd_s1 <= mem[scan_q[IDX_W-1:0]];
	end

	// control: table count, scan sequencer, read stage tokens
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			scan_q  <= '0;
			vld_s1  <= 1'b0;
			fin_s1  <= 1'b0;
			idx_s1  <= '0;
		end else begin
			if (in_acc) begin
				unique case (opcode)
					OP_CLEAR: count_q <= '0;
					OP_ADD:   if (!full) count_q <= count_q + 1'b1;
					OP_QUERY: begin
						scan_q  <= '0;
						state_q <= S_SCAN;
					end
					default: ;
				endcase
			end
			if (adv) begin
				vld_s1 <= issue;
				fin_s1 <= issue && !rd_en;
				idx_s1 <= scan_q;
				if (rd_en)
					scan_q <= scan_q + 1'b1;
				else if (issue)
					state_q <= S_WAIT;
				if (tag_s3.vld && tag_s3.fin)
					state_q <= S_IDLE;
			end
		end
	end

	// query centre and squared radius
	always_ff @(posedge clk) begin
		if (in_acc && (opcode == OP_QUERY)) begin
			cx_q <= pos_x;
			cz_q <= pos_z;
			r2_q <= R2_W'(radius) * R2_W'(radius);
		end
	end

	always_comb begin
		tag_rd.vld = vld_s1;
		tag_rd.fin = fin_s1;
		tag_rd.idx = idx_s1;
		tag_rd.x   = rd_s1[2*COORD_W-1:COORD_W];
		tag_rd.z   = rd_s1[COORD_W-1:0];
	end

	frnq_dist u_dist (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.tag_in  (tag_rd),
		.ctr_x   (cx_q),
		.ctr_z   (cz_q),
		.tag_out (tag_s3),
		.sqx     (sqx),
		.sqz     (sqz)
	);

	// compare stage
	assign d2  = {1'b0, sqx} + {1'b0, sqz};
	assign hit = (d2 <= {{(SUM_W-R2_W){1'b0}}, r2_q});

	// one match is held back so the final one can carry last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
		end else if (adv && tag_s3.vld) begin
			if (tag_s3.fin)
				pend_v_q <= 1'b0;
			else if (hit)
				pend_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && tag_s3.vld && !tag_s3.fin && hit) begin
			pend_idx_q <= tag_s3.idx;
			pend_x_q   <= tag_s3.x;
			pend_z_q   <= tag_s3.z;
		end
	end

	// result selection
	always_comb begin
		emit   = 1'b0;
		e_st   = ST_NOMATCH;
		e_idx  = '0;
		e_x    = '0;
		e_z    = '0;
		e_last = 1'b1;
		priority if (in_acc && (opcode == OP_CLEAR)) begin
			emit = 1'b1;
			e_st = ST_CLEARED;
		end else if (in_acc && (opcode == OP_ADD)) begin
			emit = 1'b1;
			if (full) begin
				e_st = ST_FULL;
			end else begin
				e_st  = ST_ADDED;
				e_idx = out_index(count_q);
			end
		end else if (adv && tag_s3.vld && (tag_s3.fin || (hit && pend_v_q))) begin
			emit = 1'b1;
			if (pend_v_q) begin
				e_st   = ST_MATCH;
				e_idx  = out_index(pend_idx_q);
				e_x    = pend_x_q;
				e_z    = pend_z_q;
				e_last = tag_s3.fin;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (emit)
			out_valid <= 1'b1;
		else if (!out_stall)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			status  <= e_st;
			index   <= e_idx;
			match_x <= e_x;
			match_z <= e_z;
			last    <= e_last;
		end
	end

endmodule

/* rtl/core/frnq_checker.sv */
module frnq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [1:0]  opcode,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  status,
	input logic [5:0]  index,
	input logic [23:0] match_x,
	input logic [23:0] match_z,
	input logic        last
);
	import frnq_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(index)
			&& $stable(match_x) && $stable(match_z) && $stable(last))
		else $error("stalled result changed");

	// every status other than a match closes its request
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_MATCH) |-> last)
		else $error("single result without last");

	// a clear request answers on the next cycle
	a_clear_resp: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (opcode == OP_CLEAR) |=>
			out_valid && (status == ST_CLEARED) && (index == 6'd0))
		else $error("clear result missing");

	// a query keeps the request side busy while it scans
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (opcode == OP_QUERY) |=> in_stall)
		else $error("request taken during a scan");

endmodule

bind fixed_radius_neighbor_query frnq_checker u_frnq_checker (.*);

/* verif/tb.sv */
module tb;
	import frnq_pkg::*;

	// opcode that the block takes and drops without a result
	localparam logic [1:0] OP_IGNORED = 2'd3;
	localparam int LIMIT_CYCLES = 500000;
	localparam int CLK_HALF = 4;

	// one result as seen on the result port
	typedef struct packed {
		logic [2:0]         status;
		logic [OUT_IDX_W-1:0] index;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] z;
		logic               last;
	} nbr_result_t;

	// Point table mirror: predicts the results of each request and
	// checks them, in order, against what the block returns.
	class neighbor_scoreboard;
		logic [COORD_W-1:0] tab_x [MAX_ITEMS];
		logic [COORD_W-1:0] tab_z [MAX_ITEMS];
		int unsigned fill;
		nbr_result_t awaited[$];
		int unsigned errors;

		function new();
			fill = 0;
			errors = 0;
		endfunction

		function void report(string msg);
			errors++;
			if (errors <= 10)
				$display("mismatch @%0t: %s", $time, msg);
		endfunction

		function void push(logic [2:0] st, int idx, logic [COORD_W-1:0] x,
				logic [COORD_W-1:0] z, logic fin);
			nbr_result_t r;
			r.status = st;
			r.index  = OUT_IDX_W'(idx);
			r.x      = x;
			r.z      = z;
			r.last   = fin;
			awaited = {awaited, r};
		endfunction

		// request taken by the block: update the table, queue its results
		function void note_request(logic [1:0] op, logic [COORD_W-1:0] px,
				logic [COORD_W-1:0] pz, logic [RAD_W-1:0] rad);
			longint dx, dz, d2, r2;
			int hits[$];
			case (op)
			OP_CLEAR: begin
				fill = 0;
				push(ST_CLEARED, 0, '0, '0, 1'b1);
			end
			OP_ADD: begin
				if (fill >= MAX_ITEMS) begin
					push(ST_FULL, 0, '0, '0, 1'b1);
				end else begin
					tab_x[fill] = px;
					tab_z[fill] = pz;
					push(ST_ADDED, fill, '0, '0, 1'b1);
					fill++;
				end
			end
			OP_QUERY: begin
				// exact squared-distance test, wide enough to never wrap
				r2 = longint'(rad) * longint'(rad);
				for (int i = 0; i < fill; i++) begin
					dx = longint'($signed(tab_x[i])) - longint'($signed(px));
					dz = longint'($signed(tab_z[i])) - longint'($signed(pz));
					d2 = dx * dx + dz * dz;
					if (d2 <= r2)
						hits = {hits, i};
				end
				if (hits.size() == 0)
					push(ST_NOMATCH, 0, '0, '0, 1'b1);
				for (int k = 0; k < hits.size(); k++)
					push(ST_MATCH, hits[k], tab_x[hits[k]], tab_z[hits[k]],
						k == hits.size() - 1);
			end
			default: ;
			endcase
		endfunction

		// result taken from the block: compare with the oldest prediction
		function void check_result(logic [2:0] st, logic [OUT_IDX_W-1:0] idx,
				logic [COORD_W-1:0] x, logic [COORD_W-1:0] z, logic fin);
			nbr_result_t want;
			if (awaited.size() == 0) begin
				report($sformatf("unexpected result st=%0d idx=%0d x=%h z=%h last=%0d",
					st, idx, x, z, fin));
				return;
			end
			want = awaited.pop_front();
			if (st !== want.status || idx !== want.index || x !== want.x ||
					z !== want.z || fin !== want.last)
				report($sformatf("exp %0d/%0d/%h/%h/%0d got %0d/%0d/%h/%h/%0d",
					want.status, want.index, want.x,
					want.z, want.last, st, idx, x, z, fin));
		endfunction

		function void close_out();
			if (awaited.size() != 0)
				report($sformatf("%0d results never arrived", awaited.size()));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [1:0] opcode;
	logic signed [23:0] pos_x;
	logic signed [23:0] pos_z;
	logic [22:0] radius;
	logic out_valid;
	logic out_stall;
	logic [2:0] status;
	logic [5:0] index;
	logic signed [23:0] match_x;
	logic signed [23:0] match_z;
	logic last;

	int send_idle_pct;
	int recv_stall_pct;
	logic [COORD_W-1:0] hot_x;
	logic [COORD_W-1:0] hot_z;
	neighbor_scoreboard board;

	fixed_radius_neighbor_query dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.pos_x(pos_x),
		.pos_z(pos_z),
		.radius(radius),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.index(index),
		.match_x(match_x),
		.match_z(match_z),
		.last(last)
	);

	initial clk = 1'b0;
	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// coordinate within a couple of thousand LSBs of a cluster center
	function automatic logic [COORD_W-1:0] near(input logic [COORD_W-1:0] base);
		return base + COORD_W'($urandom_range(4095)) - COORD_W'(2048);
	endfunction

	function automatic logic [COORD_W-1:0] pick_coord(input logic [COORD_W-1:0] base);
		if ($urandom_range(3) == 0)
			return COORD_W'($urandom);
		return near(base);
	endfunction

	function automatic logic [RAD_W-1:0] pick_radius();
		case ($urandom_range(5))
		0: return '0;
		1: return '1;
		2: return RAD_W'($urandom);
		default: return RAD_W'($urandom_range(4095));
		endcase
	endfunction

	// cluster center kept clear of the signed wrap point
	function automatic logic [COORD_W-1:0] pick_center();
		return COORD_W'(int'($urandom_range(16777216 - 8192)) - 8384512);
	endfunction

	// drive one request, idling first at the sender's rate
	task automatic send_request(input logic [1:0] op, input logic [COORD_W-1:0] px,
			input logic [COORD_W-1:0] pz, input logic [RAD_W-1:0] rad);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			opcode <= 2'($urandom);
			pos_x <= COORD_W'($urandom);
			pos_z <= COORD_W'($urandom);
			radius <= RAD_W'($urandom);
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		pos_x <= px;
		pos_z <= pz;
		radius <= rad;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		board.note_request(op, px, pz, rad);
	endtask

	// random request mix; dropped opcodes do not count
	task automatic random_request(output bit counted);
		int pick;
		pick = $urandom_range(99);
		counted = 1'b1;
		if (pick < 6) begin
			send_request(OP_CLEAR, COORD_W'($urandom), COORD_W'($urandom),
				RAD_W'($urandom));
		end else if (pick < 10) begin
			send_request(OP_IGNORED, COORD_W'($urandom), COORD_W'($urandom),
				RAD_W'($urandom));
			counted = 1'b0;
		end else if (pick < 58) begin
			send_request(OP_ADD, pick_coord(hot_x), pick_coord(hot_z), RAD_W'($urandom));
		end else begin
			send_request(OP_QUERY, pick_coord(hot_x), pick_coord(hot_z), pick_radius());
		end
	endtask

	// fill the table to the top, overflow it, then sweep it whole
	task automatic fill_table();
		while (board.fill < MAX_ITEMS)
			send_request(OP_ADD, near(hot_x), near(hot_z), RAD_W'($urandom));
		repeat (2)
			send_request(OP_ADD, near(hot_x), near(hot_z), RAD_W'($urandom));
		send_request(OP_QUERY, hot_x, hot_z, '1);
		send_request(OP_QUERY, near(hot_x), near(hot_z), RAD_W'($urandom_range(2047)));
	endtask

	// stop sending until every predicted result has come back
	task automatic hold_until_drained();
		in_valid <= 1'b0;
		while (board.awaited.size() != 0)
			@(posedge clk);
		repeat (MAX_ITEMS + 8)
			@(posedge clk);
	endtask

	// result side: random stall, check every accepted result
	initial begin
		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall)
				board.check_result(status, index, match_x, match_z, last);
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// request side: reset, directed requests, then random phases
	initial begin
		bit counted;
		int done;
		board = new();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		opcode <= OP_CLEAR;
		pos_x <= '0;
		pos_z <= '0;
		radius <= '0;
		repeat (3)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table after reset
		send_request(OP_QUERY, '0, '0, '1);
		// corner points and an exact-boundary point
		send_request(OP_ADD, 24'h800000, 24'h800000, '0);
		send_request(OP_ADD, 24'h7FFFFF, 24'h7FFFFF, '1);
		send_request(OP_ADD, '0, '0, '0);
		send_request(OP_ADD, 24'd768, 24'd1024, '0);
		send_request(OP_ADD, 24'hFFFFFF, 24'd1, '0);
		// zero radius, distance equal to radius, one below, widest radius
		send_request(OP_QUERY, '0, '0, '0);
		send_request(OP_QUERY, '0, '0, 23'd1280);
		send_request(OP_QUERY, '0, '0, 23'd1279);
		send_request(OP_QUERY, '0, '0, '1);
		send_request(OP_QUERY, 24'h800000, 24'h800000, '0);
		send_request(OP_QUERY, 24'h7FFFFF, 24'h7FFFFF, '1);
		send_request(OP_QUERY, 24'h7FFFFF, 24'h800000, '1);
		// dropped opcode leaves the table alone
		send_request(OP_IGNORED, 24'h7FFFFF, 24'h800000, '1);
		send_request(OP_ADD, 24'h123456, 24'hABCDEF, '0);
		// clear, then reuse from index zero
		send_request(OP_CLEAR, 24'h7FFFFF, 24'h7FFFFF, '1);
		send_request(OP_QUERY, '0, '0, '1);
		send_request(OP_ADD, 24'h800000, 24'h7FFFFF, '0);
		send_request(OP_QUERY, 24'h800000, 24'h7FFFFF, '0);
		send_request(OP_IGNORED, '0, '0, '0);
		send_request(OP_CLEAR, '0, '0, '0);
		hold_until_drained();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
			0: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			1: begin
				send_idle_pct = 83;
				recv_stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				recv_stall_pct = 83;
			end
			default: begin
				send_idle_pct = 36;
				recv_stall_pct = 36;
			end
			endcase
			hot_x = pick_center();
			hot_z = pick_center();
			if (ph == 2)
				fill_table();
			done = 0;
			while (done < 28) begin
				random_request(counted);
				if (counted)
					done++;
			end
			hold_until_drained();
		end

		board.close_out();
		if (board.errors == 0)
			$display("** fixed_radius_neighbor_query: PASSED **");
		else
			$display("** fixed_radius_neighbor_query: FAILED **");
		$finish;
	end

	// watchdog
	initial begin
		#(LIMIT_CYCLES * 2 * CLK_HALF);
		$display("** fixed_radius_neighbor_query: FAILED **");
		$finish;
	end

endmodule

/* fixed_radius_neighbor_query.f */
rtl/core/frnq_pkg.sv
rtl/core/frnq_dist.sv
rtl/core/fixed_radius_neighbor_query.sv
rtl/core/frnq_checker.sv
verif/tb.sv
